// ----- src/acs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package acs_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int VALUE_BITS  = 32;
  localparam int SUM_BITS    = 27;
  localparam int OFFSET_BITS = SAMPLE_BITS + 1;
  localparam int DIFF_BITS   = SAMPLE_BITS + 2;
  localparam int SHIFT_BITS  = 4;
  localparam int MAP_BITS    = 8;
  localparam int SCALE_BITS  = 16;
  localparam int FRAMES_BITS = 16;
  localparam int RAW_COUNT   = 4;
  localparam int SEL_BITS    = 2;
  localparam int PROD_BITS   = DIFF_BITS + SCALE_BITS;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_AVG_SHIFT   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_MAP = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_CH0   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_CH1   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_CH2   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_CH3   = 3'd5;

  localparam logic [SHIFT_BITS-1:0] AVG_SHIFT_RESET   = 4'd4;
  localparam logic [MAP_BITS-1:0]   CHANNEL_MAP_RESET = 8'd228;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET       = 16'd1;

  typedef struct packed {
    logic                   restart;
    logic [SAMPLE_BITS-1:0] raw_0;
    logic [SAMPLE_BITS-1:0] raw_1;
    logic [SAMPLE_BITS-1:0] raw_2;
    logic [SAMPLE_BITS-1:0] raw_3;
  } acs_in_t;

  typedef struct packed {
    logic                         calibrated;
    logic signed [VALUE_BITS-1:0] value_0;
    logic signed [VALUE_BITS-1:0] value_1;
    logic signed [VALUE_BITS-1:0] value_2;
    logic signed [VALUE_BITS-1:0] value_3;
  } acs_out_t;

  typedef logic [RAW_COUNT-1:0][SCALE_BITS-1:0] acs_scales_t;

  typedef struct packed {
    logic                  advance;
    logic                  restart;
    logic                  calibrated;
    logic                  last;
    logic [SHIFT_BITS-1:0] shift;
  } acs_ctl_t;

endpackage

`default_nettype wire

// ----- src/acs_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module acs_cfg (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [acs_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  wire logic [acs_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  output logic [acs_pkg::SHIFT_BITS-1:0]            avg_shift_o,
  output logic [acs_pkg::MAP_BITS-1:0]              channel_map_o,
  output acs_pkg::acs_scales_t                      scales_o
);

  logic [acs_pkg::SHIFT_BITS-1:0] shift_q, shift_d;
  logic [acs_pkg::MAP_BITS-1:0]   map_q, map_d;
  acs_pkg::acs_scales_t           scales_q, scales_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    shift_d  = shift_q;
    map_d    = map_q;
    scales_d = scales_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        acs_pkg::REG_AVG_SHIFT:   shift_d     = cfg_data_i[acs_pkg::SHIFT_BITS-1:0];
        acs_pkg::REG_CHANNEL_MAP: map_d       = cfg_data_i[acs_pkg::MAP_BITS-1:0];
        acs_pkg::REG_SCALE_CH0:   scales_d[0] = cfg_data_i[acs_pkg::SCALE_BITS-1:0];
        acs_pkg::REG_SCALE_CH1:   scales_d[1] = cfg_data_i[acs_pkg::SCALE_BITS-1:0];
        acs_pkg::REG_SCALE_CH2:   scales_d[2] = cfg_data_i[acs_pkg::SCALE_BITS-1:0];
        acs_pkg::REG_SCALE_CH3:   scales_d[3] = cfg_data_i[acs_pkg::SCALE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= acs_pkg::AVG_SHIFT_RESET;
      map_q    <= acs_pkg::CHANNEL_MAP_RESET;
      scales_q <= {acs_pkg::RAW_COUNT{acs_pkg::SCALE_RESET}};
    end else begin
      shift_q  <= shift_d;
      map_q    <= map_d;
      scales_q <= scales_d;
    end
  end

  assign avg_shift_o   = shift_q;
  assign channel_map_o = map_q;
  assign scales_o      = scales_q;

endmodule

`default_nettype wire

// ----- src/acs_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module acs_lane (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire acs_pkg::acs_ctl_t                     ctl_i,
  input  wire logic [acs_pkg::SAMPLE_BITS-1:0]       sample_i,
  input  wire logic signed [acs_pkg::SCALE_BITS-1:0] scale_i,
  output logic [acs_pkg::VALUE_BITS-1:0]             value_o
);

  localparam int SumBits  = acs_pkg::SUM_BITS;
  localparam int ProdBits = acs_pkg::PROD_BITS;

  logic [SumBits-1:0]                  sum_q, sum_d;
  logic [acs_pkg::OFFSET_BITS-1:0]     offset_q, offset_d;
  logic [acs_pkg::VALUE_BITS-1:0]      value_q, value_d;

  logic [SumBits-1:0]                  sum_add;
  logic [SumBits:0]                    bias;
  logic [SumBits:0]                    biased;
  logic [SumBits:0]                    mean;
  logic [acs_pkg::OFFSET_BITS-1:0]     new_offset;
  logic [acs_pkg::OFFSET_BITS-1:0]     use_offset;
  logic signed [acs_pkg::DIFF_BITS-1:0] diff;
  logic signed [ProdBits-1:0]          prod;

  assign sum_add = sum_q + SumBits'(sample_i);
  assign bias    = (ctl_i.shift == '0) ? '0 :
                   ((SumBits+1)'(1) << (ctl_i.shift - acs_pkg::SHIFT_BITS'(1)));
  assign biased  = {1'b0, sum_add} + bias;
  assign mean    = biased >> ctl_i.shift;
  assign new_offset = {1'b0, mean[acs_pkg::SAMPLE_BITS-1:0]} + acs_pkg::OFFSET_BITS'(1);
  assign use_offset = ctl_i.calibrated ? offset_q : new_offset;
  assign diff    = $signed({2'b00, sample_i}) - $signed({1'b0, use_offset});
  assign prod    = ProdBits'(diff) * ProdBits'(scale_i);

  always_comb begin
    sum_d    = sum_q;
    offset_d = offset_q;
    value_d  = value_q;
    if (ctl_i.advance) begin
      if (ctl_i.restart) begin
        sum_d = '0;
      end else if (ctl_i.calibrated) begin
        value_d = acs_pkg::VALUE_BITS'(prod);
      end else if (ctl_i.last) begin
        sum_d    = '0;
        offset_d = new_offset;
        value_d  = acs_pkg::VALUE_BITS'(prod);
      end else begin
        sum_d = sum_add;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      offset_q <= '0;
      value_q  <= '0;
    end else begin
      sum_q    <= sum_d;
      offset_q <= offset_d;
      value_q  <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

// ----- src/adc_offset_calibrate_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  acs_in_t: restart, raw_0..raw_3
// out      output     out_valid / out_stall acs_out_t: calibrated, value_0..value_3
// cfg      input      cfg_valid / cfg_ready cfg_index (3 bits), cfg_data (16 bits)
//
// One frame per cycle while out_stall is low: input register, then the per-channel
// sum, rounding and 14x16 multiply into the result register.
// Reset clears sums, offsets and held values, reloads the frame count from the
// average shift and loads register defaults. out_stall holds the result
// register and back-pressures the input register; cfg writes complete at once.

module adc_offset_calibrate_scale #(
  parameter int CHANNELS = 4
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire acs_pkg::acs_in_t                   in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output acs_pkg::acs_out_t                       out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [acs_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [acs_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam int FrameBits = acs_pkg::FRAMES_BITS;

  logic [acs_pkg::SHIFT_BITS-1:0] avg_shift;
  logic [acs_pkg::MAP_BITS-1:0]   channel_map;
  acs_pkg::acs_scales_t           scales;

  logic             s1_valid_q, s1_valid_d;
  acs_pkg::acs_in_t s1_data_q;
  logic             out_valid_q, out_valid_d;
  logic             cal_q, cal_d;
  logic [FrameBits-1:0] frames_q, frames_d;
  logic [FrameBits-1:0] frames_reload;
  logic             adv;
  acs_pkg::acs_ctl_t ctl;

  logic [acs_pkg::RAW_COUNT-1:0][acs_pkg::SAMPLE_BITS-1:0] raw;
  logic [acs_pkg::RAW_COUNT-1:0][acs_pkg::VALUE_BITS-1:0]  vals;

  acs_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .avg_shift_o   (avg_shift),
    .channel_map_o (channel_map),
    .scales_o      (scales)
  );

  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign s1_valid_d = in_stall_o ? s1_valid_q : in_valid_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign frames_reload = FrameBits'(1) << avg_shift;

  always_comb begin
    frames_d = frames_q;
    cal_d    = cal_q;
    if (adv) begin
      if (s1_data_q.restart) begin
        frames_d = frames_reload;
        cal_d    = 1'b0;
      end else if (!cal_q) begin
        if (ctl.last) begin
          frames_d = frames_reload;
          cal_d    = 1'b1;
        end else begin
          frames_d = frames_q - FrameBits'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cal_q       <= 1'b0;
      frames_q    <= FrameBits'(1) << acs_pkg::AVG_SHIFT_RESET;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      cal_q       <= cal_d;
      frames_q    <= frames_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= in_data_i;
    end
  end

  assign ctl.advance    = adv;
  assign ctl.restart    = s1_data_q.restart;
  assign ctl.calibrated = cal_q;
  assign ctl.last       = (frames_q == FrameBits'(1));
  assign ctl.shift      = avg_shift;

  assign raw[0] = s1_data_q.raw_0;
  assign raw[1] = s1_data_q.raw_1;
  assign raw[2] = s1_data_q.raw_2;
  assign raw[3] = s1_data_q.raw_3;

  for (genvar ch = 0; ch < acs_pkg::RAW_COUNT; ch++) begin : g_lane
    if (ch < CHANNELS) begin : g_on
      logic [acs_pkg::SEL_BITS-1:0] sel;
      assign sel = channel_map[acs_pkg::SEL_BITS*ch +: acs_pkg::SEL_BITS];
      acs_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctl_i    (ctl),
        .sample_i (raw[sel]),
        .scale_i  ($signed(scales[ch])),
        .value_o  (vals[ch])
      );
    end else begin : g_off
      assign vals[ch] = '0;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_data_o.calibrated = cal_q;
  assign out_data_o.value_0    = vals[0];
  assign out_data_o.value_1    = vals[1];
  assign out_data_o.value_2    = vals[2];
  assign out_data_o.value_3    = vals[3];

  a_frames_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_q != '0)
    else $error("frame count reached zero");

  a_cal_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cal_q) |-> $past(adv && !s1_data_q.restart && ctl.last))
    else $error("calibration set outside the last frame of a run");

  a_hold_uncal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cal_q |-> $stable(vals))
    else $error("values changed while not calibrated");

  a_out_on_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("advanced request produced no result");

endmodule

`default_nettype wire
